>>> rtl/svae_pkg.sv
// shared types, constants and the sine table function of the sine voice
`timescale 1ns / 1ps
`default_nettype none
package svae_pkg;

    localparam int SINE_ENTRIES_DEF = 1024;
    localparam int SAMPLE_BITS_DEF  = 24;

    localparam int KIND_W  = 2;
    localparam int FIELD_W = 16;
    localparam int RATE_W  = 18;
    localparam int FREQ_W  = 15;
    localparam int GAIN_W  = 16;
    localparam int MS_W    = 13;
    localparam int MPROD_W = MS_W + RATE_W;
    localparam int CNT_W   = 21;
    localparam int WAVE_W  = 14;
    localparam int SINE_W  = 24;
    localparam int ENV_W   = 40;
    localparam int PROD_W  = 64;

    // shared unit: dividend / multiplier operand, divisor / multiplicand, result
    localparam int ALU_A_W   = 38;
    localparam int ALU_B_W   = 24;
    localparam int ALU_P_W   = ALU_A_W + ALU_B_W;
    localparam int ALU_CNT_W = $clog2(ALU_A_W + 1);

    localparam logic [RATE_W-1:0]  RATE_RESET   = RATE_W'(48000);
    localparam logic [WAVE_W-1:0]  PERIOD_RESET = WAVE_W'(120);
    localparam logic [WAVE_W-1:0]  PERIOD_MAX   = WAVE_W'(16383);
    localparam logic [GAIN_W-1:0]  GAIN_RESET   = GAIN_W'(3277);
    localparam logic [GAIN_W-1:0]  GAIN_MAX     = GAIN_W'(32768);
    localparam logic [FIELD_W-1:0] FREQ_MIN     = FIELD_W'(20);
    localparam logic [FIELD_W-1:0] FREQ_MAX     = FIELD_W'(20000);
    localparam logic [FIELD_W-1:0] MS_MAX       = FIELD_W'(8000);
    localparam logic [ALU_B_W-1:0] MS_PER_SEC   = ALU_B_W'(1000);
    localparam logic [ALU_A_W-1:0] MS_ROUND     = ALU_A_W'(500);
    localparam logic signed [ENV_W-1:0] ENV_ONE = ENV_W'(65536);

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK     = 2'd0,
        KIND_NOTE_ON  = 2'd1,
        KIND_NOTE_OFF = 2'd2,
        KIND_UNUSED   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_RELEASE = 2'd3
    } t_env_phase;

    typedef enum logic {
        ALU_DIV = 1'b0,
        ALU_MUL = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] SINE_AMP    = 64'd8388607;
    localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210};

    // q1.23 sine of a q30 angle in 0..2pi, taylor series folded to the first quadrant
    function automatic logic signed [SINE_W-1:0] sine_q23(input logic [63:0] ang);
        logic [63:0] a;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] mag;
        logic signed [63:0] sum;
        logic neg;
        a   = ang;
        neg = 1'b0;
        if (a > PI_Q30) begin
            neg = 1'b1;
            a   = a - PI_Q30;
        end
        if (a > HALF_PI_Q30) begin
            a = (a >= PI_Q30) ? 64'd0 : PI_Q30 - a;
        end
        x2   = (a * a) >> 30;
        term = a;
        sum  = $signed(a);
        for (int k = 0; k < 7; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if (k % 2 == 0) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) sum = 64'sd0;
        if (sum > $signed(ONE_Q30)) sum = $signed(ONE_Q30);
        mag = ((64'(sum) * SINE_AMP) + (ONE_Q30 >> 1)) >> 30;
        if (mag > SINE_AMP) mag = SINE_AMP;
        return neg ? -SINE_W'(mag) : SINE_W'(mag);
    endfunction

endpackage
`default_nettype wire

>>> rtl/svae_alu.sv
// shared bit-serial unit: restoring divide or shift-add multiply, one bit a cycle
`timescale 1ns / 1ps
`default_nettype none
module svae_alu
    import svae_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_alu_ctl           i_ctl,
    input  wire logic [ALU_A_W-1:0] i_a,
    input  wire logic [ALU_B_W-1:0] i_b,
    output logic                    o_done,
    output logic [ALU_P_W-1:0]      o_result
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    t_alu_op              r_op, n_op;
    logic [ALU_CNT_W-1:0] r_cnt, n_cnt;
    logic [ALU_A_W-1:0]   r_a, n_a;
    logic [ALU_B_W-1:0]   r_b, n_b;
    logic [ALU_B_W-1:0]   r_rem, n_rem;
    logic [ALU_P_W-1:0]   r_acc, n_acc;
    logic [ALU_B_W:0]     w_rem_sh;
    logic [ALU_B_W:0]     w_rem_sub;

    always_comb begin
        w_rem_sh  = {r_rem, r_a[ALU_A_W-1]};
        w_rem_sub = w_rem_sh - {1'b0, r_b};
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_rem  = r_rem;
        n_acc  = r_acc;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_op   = i_ctl.op;
            n_cnt  = ALU_CNT_W'(ALU_A_W);
            n_a    = i_a;
            n_b    = i_b;
            n_rem  = '0;
            n_acc  = '0;
        end else if (r_busy) begin
            n_a = {r_a[ALU_A_W-2:0], 1'b0};
            case (r_op)
                ALU_DIV: begin
                    if (w_rem_sh >= {1'b0, r_b}) begin
                        n_rem = w_rem_sub[ALU_B_W-1:0];
                        n_acc = {r_acc[ALU_P_W-2:0], 1'b1};
                    end else begin
                        n_rem = w_rem_sh[ALU_B_W-1:0];
                        n_acc = {r_acc[ALU_P_W-2:0], 1'b0};
                    end
                end
                ALU_MUL: begin
                    n_acc = {r_acc[ALU_P_W-2:0], 1'b0}
                          + (r_a[ALU_A_W-1] ? ALU_P_W'(r_b) : '0);
                end
                default: n_acc = r_acc;
            endcase
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == ALU_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= ALU_DIV;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_rem <= n_rem;
        r_acc <= n_acc;
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule
`default_nettype wire

>>> rtl/svae_sine_rom.sv
// full-wave sine table with registered read
`timescale 1ns / 1ps
`default_nettype none
module svae_sine_rom
    import svae_pkg::*;
#(
    parameter int ENTRIES = SINE_ENTRIES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic [$clog2(ENTRIES)-1:0] i_addr,
    output logic signed [SINE_W-1:0]        o_data
);

    logic signed [SINE_W-1:0] w_tab [ENTRIES];
    logic signed [SINE_W-1:0] r_data;

    for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_ent
        localparam logic [63:0] ANG = (64'(gi) * TWO_PI_Q30) / 64'(ENTRIES);
        localparam logic signed [SINE_W-1:0] VAL = sine_q23(ANG);
        assign w_tab[gi] = VAL;
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_tab[i_addr];
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

>>> rtl/sine_voice_with_ar_envelope.sv
// top level: one sine voice with attack/release envelope, sequenced over a shared unit
//
//  channel   dir  handshake                       payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tuser kind, tdata note and mix_in
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata mix_out, voice_active
//  cfg       in   i_cfg_valid/o_cfg_ready         sample_rate
//
//  a tick holds the input off through its index pass, in attack or release an envelope
//  pass, its envelope times gain pass and its gain and output steps, all on the shared
//  bit-serial divide/multiply unit
//  a note-on holds it off for its period and two envelope length passes, note-off for none
//  a tick also waits in its output step while the previous result is still unaccepted
//  i_rst_n is synchronous; the sine table is constant and needs no fill after reset
`timescale 1ns / 1ps
`default_nettype none
module sine_voice_with_ar_envelope
    import svae_pkg::*;
#(
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    localparam int IN_DATA_W   = ((4 * FIELD_W + SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W  = ((SAMPLE_BITS + 1 + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // frequency_hz, gain, attack_ms, release_ms, mix_in
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // kind
    input  wire logic [KIND_W-1:0]     i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // mix_out, voice_active
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [RATE_W-1:0]     i_cfg_data
);

    localparam int IDX_W = $clog2(SINE_ENTRIES);
    localparam int SH_L  = (SAMPLE_BITS >= 24) ? SAMPLE_BITS - 24 : 0;
    localparam int SH_R  = (SAMPLE_BITS >= 24) ? 0 : 24 - SAMPLE_BITS;
    localparam logic signed [PROD_W-1:0] SAT_MAX =
        (PROD_W'(1) <<< (SAMPLE_BITS - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] SAT_MIN = -(PROD_W'(1) <<< (SAMPLE_BITS - 1));

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_ON_PER   = 14'b00000000000010,
        S_ON_PER_W = 14'b00000000000100,
        S_ON_ATK   = 14'b00000000001000,
        S_ON_ATK_W = 14'b00000000010000,
        S_ON_REL   = 14'b00000000100000,
        S_ON_REL_W = 14'b00000001000000,
        S_T_IDX    = 14'b00000010000000,
        S_T_IDX_W  = 14'b00000100000000,
        S_T_ROM    = 14'b00001000000000,
        S_T_ENV_W  = 14'b00010000000000,
        S_T_GAIN   = 14'b00100000000000,
        S_T_MUL_W  = 14'b01000000000000,
        S_T_OUT    = 14'b10000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [RATE_W-1:0]  r_rate;
    t_env_phase r_phase, n_phase;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [WAVE_W-1:0]  r_wave, n_wave;
    logic [WAVE_W-1:0]  r_per, n_per;
    logic [GAIN_W-1:0]  r_gain, n_gain;
    logic [CNT_W-1:0]   r_atk_len, n_atk_len;
    logic [CNT_W-1:0]   r_rel_len, n_rel_len;
    logic [FREQ_W-1:0]  r_freq, n_freq;
    logic [MS_W-1:0]    r_atk_ms, n_atk_ms;
    logic [MS_W-1:0]    r_rel_ms, n_rel_ms;
    logic [MPROD_W-1:0] r_mprod, n_mprod;
    logic signed [SAMPLE_BITS-1:0] r_mix, n_mix;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic signed [ENV_W-1:0]  r_env, n_env;
    logic signed [SINE_W-1:0] r_g, n_g;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic                     r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_mix, n_out_mix;
    logic                     r_out_act, n_out_act;

    t_alu_ctl              w_alu_ctl;
    logic [ALU_A_W-1:0]    w_alu_a;
    logic [ALU_B_W-1:0]    w_alu_b;
    logic                  w_alu_done;
    logic [ALU_P_W-1:0]    w_alu_res;
    logic signed [SINE_W-1:0] w_sine;

    logic                  w_in_beat;
    t_kind                 w_kind;
    logic [FIELD_W-1:0]    w_f, w_gn, w_at, w_rl;
    logic [CNT_W-1:0]      w_len;
    logic [CNT_W-1:0]      w_cnt_inc;
    logic signed [41:0]    w_gmul;
    logic signed [SINE_W-1:0] w_g;
    logic [ENV_W-1:0]      w_env_mag;
    logic [SINE_W-1:0]     w_g_mag;
    logic signed [PROD_W-1:0] w_voice;
    logic signed [PROD_W-1:0] w_sum;
    logic signed [PROD_W-1:0] w_prod_mag;

    svae_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_alu_ctl),
        .i_a      (w_alu_a),
        .i_b      (w_alu_b),
        .o_done   (w_alu_done),
        .o_result (w_alu_res)
    );

    svae_sine_rom #(
        .ENTRIES (SINE_ENTRIES)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_idx),
        .o_data (w_sine)
    );

    assign w_in_beat = i_s_axis_tvalid && o_s_axis_tready;
    assign w_kind    = t_kind'(i_s_axis_tuser);
    assign w_f       = i_s_axis_tdata[FIELD_W-1:0];
    assign w_gn      = i_s_axis_tdata[2*FIELD_W-1:FIELD_W];
    assign w_at      = i_s_axis_tdata[3*FIELD_W-1:2*FIELD_W];
    assign w_rl      = i_s_axis_tdata[4*FIELD_W-1:3*FIELD_W];

    always_comb begin
        w_len      = (r_phase == PH_ATTACK) ? r_atk_len : r_rel_len;
        w_cnt_inc  = r_count + 1'b1;
        w_gmul     = $signed({26'd0, r_gain}) * 42'(w_sine);
        w_g        = SINE_W'(w_gmul >>> 15);
        w_env_mag  = r_env[ENV_W-1] ? ENV_W'(-r_env) : ENV_W'(r_env);
        w_g_mag    = w_g[SINE_W-1] ? SINE_W'(-w_g) : SINE_W'(w_g);
        w_prod_mag = $signed({2'b00, w_alu_res});
        w_voice    = ((r_prod >>> 16) <<< SH_L) >>> SH_R;
        w_sum      = PROD_W'(r_mix) + w_voice;
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_count     = r_count;
        n_wave      = r_wave;
        n_per       = r_per;
        n_gain      = r_gain;
        n_atk_len   = r_atk_len;
        n_rel_len   = r_rel_len;
        n_freq      = r_freq;
        n_atk_ms    = r_atk_ms;
        n_rel_ms    = r_rel_ms;
        n_mprod     = r_mprod;
        n_mix       = r_mix;
        n_idx       = r_idx;
        n_env       = r_env;
        n_g         = r_g;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_mix   = r_out_mix;
        n_out_act   = r_out_act;
        w_alu_ctl   = '{start: 1'b0, op: ALU_DIV};
        w_alu_a     = '0;
        w_alu_b     = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    case (w_kind)
                        KIND_TICK: begin
                            n_mix   = $signed(i_s_axis_tdata[4*FIELD_W +: SAMPLE_BITS]);
                            n_state = S_T_IDX;
                        end
                        KIND_NOTE_ON: begin
                            n_freq   = FREQ_W'((w_f < FREQ_MIN) ? FREQ_MIN :
                                               (w_f > FREQ_MAX) ? FREQ_MAX : w_f);
                            n_gain   = (w_gn > GAIN_MAX) ? GAIN_MAX : w_gn;
                            n_atk_ms = MS_W'((w_at > MS_MAX) ? MS_MAX : w_at);
                            n_rel_ms = MS_W'((w_rl > MS_MAX) ? MS_MAX : w_rl);
                            n_state  = S_ON_PER;
                        end
                        KIND_NOTE_OFF: begin
                            if (r_phase == PH_ATTACK || r_phase == PH_SUSTAIN) begin
                                n_phase = PH_RELEASE;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ON_PER: begin
                w_alu_ctl = '{start: 1'b1, op: ALU_DIV};
                w_alu_a   = ALU_A_W'(r_rate);
                w_alu_b   = ALU_B_W'(r_freq);
                n_mprod   = MPROD_W'(r_atk_ms) * MPROD_W'(r_rate);
                n_state   = S_ON_PER_W;
            end
            S_ON_PER_W: begin
                if (w_alu_done) begin
                    if (w_alu_res == '0) begin
                        n_per = WAVE_W'(1);
                    end else if (w_alu_res > ALU_P_W'(PERIOD_MAX)) begin
                        n_per = PERIOD_MAX;
                    end else begin
                        n_per = w_alu_res[WAVE_W-1:0];
                    end
                    n_state = S_ON_ATK;
                end
            end
            S_ON_ATK: begin
                w_alu_ctl = '{start: 1'b1, op: ALU_DIV};
                w_alu_a   = ALU_A_W'(r_mprod) + MS_ROUND;
                w_alu_b   = MS_PER_SEC;
                n_mprod   = MPROD_W'(r_rel_ms) * MPROD_W'(r_rate);
                n_state   = S_ON_ATK_W;
            end
            S_ON_ATK_W: begin
                if (w_alu_done) begin
                    n_atk_len = (w_alu_res == '0) ? CNT_W'(1) : w_alu_res[CNT_W-1:0];
                    n_state   = S_ON_REL;
                end
            end
            S_ON_REL: begin
                w_alu_ctl = '{start: 1'b1, op: ALU_DIV};
                w_alu_a   = ALU_A_W'(r_mprod) + MS_ROUND;
                w_alu_b   = MS_PER_SEC;
                n_state   = S_ON_REL_W;
            end
            S_ON_REL_W: begin
                if (w_alu_done) begin
                    n_rel_len = (w_alu_res == '0) ? CNT_W'(1) : w_alu_res[CNT_W-1:0];
                    n_phase   = PH_ATTACK;
                    n_count   = '0;
                    n_wave    = '0;
                    n_state   = S_IDLE;
                end
            end
            S_T_IDX: begin
                // table index = wave * entries / period, wave always below period
                w_alu_ctl = '{start: 1'b1, op: ALU_DIV};
                w_alu_a   = ALU_A_W'(r_wave) * ALU_A_W'(SINE_ENTRIES);
                w_alu_b   = ALU_B_W'(r_per);
                n_state   = S_T_IDX_W;
            end
            S_T_IDX_W: begin
                if (w_alu_done) begin
                    n_idx   = w_alu_res[IDX_W-1:0];
                    n_state = S_T_ROM;
                end
            end
            S_T_ROM: begin
                if (r_phase == PH_ATTACK || r_phase == PH_RELEASE) begin
                    w_alu_ctl = '{start: 1'b1, op: ALU_DIV};
                    w_alu_a   = ALU_A_W'({r_count, 16'd0});
                    w_alu_b   = ALU_B_W'(w_len);
                    n_state   = S_T_ENV_W;
                end else begin
                    n_env   = (r_phase == PH_SUSTAIN) ? ENV_ONE : '0;
                    n_state = S_T_GAIN;
                end
            end
            S_T_ENV_W: begin
                if (w_alu_done) begin
                    if (r_phase == PH_ATTACK) begin
                        n_env = $signed(w_alu_res[ENV_W-1:0]);
                    end else begin
                        n_env = ENV_ONE - $signed(w_alu_res[ENV_W-1:0]);
                    end
                    // envelope advances once its value is taken
                    if (w_cnt_inc >= w_len) begin
                        n_count = '0;
                        n_phase = (r_phase == PH_ATTACK) ? PH_SUSTAIN : PH_IDLE;
                    end else begin
                        n_count = w_cnt_inc;
                    end
                    n_state = S_T_GAIN;
                end
            end
            S_T_GAIN: begin
                // magnitude multiply of envelope and gained sine
                w_alu_ctl = '{start: 1'b1, op: ALU_MUL};
                w_alu_a   = ALU_A_W'(w_env_mag);
                w_alu_b   = ALU_B_W'(w_g_mag);
                n_g       = w_g;
                n_state   = S_T_MUL_W;
            end
            S_T_MUL_W: begin
                // sign is applied on the magnitude product
                if (w_alu_done) begin
                    n_prod  = (r_env[ENV_W-1] ^ r_g[SINE_W-1]) ? -w_prod_mag : w_prod_mag;
                    n_state = S_T_OUT;
                end
            end
            S_T_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    if (w_sum > SAT_MAX) begin
                        n_out_mix = SAMPLE_BITS'(SAT_MAX);
                    end else if (w_sum < SAT_MIN) begin
                        n_out_mix = SAMPLE_BITS'(SAT_MIN);
                    end else begin
                        n_out_mix = SAMPLE_BITS'(w_sum);
                    end
                    n_out_act = (r_phase != PH_IDLE);
                    n_wave    = (WAVE_W'(r_wave + 1'b1) == r_per) ? '0 : r_wave + 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= RATE_RESET;
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_wave      <= '0;
            r_per       <= PERIOD_RESET;
            r_gain      <= GAIN_RESET;
            r_atk_len   <= CNT_W'(1);
            r_rel_len   <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_valid) begin
                r_rate <= i_cfg_data;
            end
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_wave      <= n_wave;
            r_per       <= n_per;
            r_gain      <= n_gain;
            r_atk_len   <= n_atk_len;
            r_rel_len   <= n_rel_len;
            r_out_valid <= n_out_valid;
        end
        r_freq    <= n_freq;
        r_atk_ms  <= n_atk_ms;
        r_rel_ms  <= n_rel_ms;
        r_mprod   <= n_mprod;
        r_mix     <= n_mix;
        r_idx     <= n_idx;
        r_env     <= n_env;
        r_g       <= n_g;
        r_prod    <= n_prod;
        r_out_mix <= n_out_mix;
        r_out_act <= n_out_act;
    end

    always_comb begin
        o_m_axis_tdata                = '0;
        o_m_axis_tdata[SAMPLE_BITS-1:0] = r_out_mix;
        o_m_axis_tdata[SAMPLE_BITS]   = r_out_act;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_cfg_ready     = 1'b1;

endmodule
`default_nettype wire

>>> rtl/svae_checker.sv
// port-level checks of the sine voice, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module svae_checker
    import svae_pkg::*;
#(
    parameter int OUT_DATA_W = 32
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic [KIND_W-1:0]     i_s_axis_tuser,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result beat changed while stalled");

    // a tick keeps the block busy; only the start of its computation is checked
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == KIND_TICK
        |=> !o_s_axis_tready ##1 !o_s_axis_tready)
        else $error("ready returned too early after a tick");

    // note-off and unused kinds finish in the cycle they are taken
    a_off_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready &&
        (i_s_axis_tuser == KIND_NOTE_OFF || i_s_axis_tuser == KIND_UNUSED)
        |=> o_s_axis_tready)
        else $error("note-off or unused kind stalled the input");

endmodule

bind sine_voice_with_ar_envelope svae_checker #(
    .OUT_DATA_W (OUT_DATA_W)
) u_svae_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench for the sine voice with attack/release envelope
`timescale 1ns / 1ps
module tb_top;
    import svae_pkg::*;

    localparam int IN_W      = 88;
    localparam int OUT_W     = 32;
    localparam int N_ITEMS   = 1800;
    localparam int SETTLE    = 300;
    localparam int CYC_LIMIT = 3000000;

    typedef struct {
        t_kind       kind;
        logic [15:0] freq;
        logic [15:0] gain;
        logic [15:0] atk_ms;
        logic [15:0] rel_ms;
        logic [23:0] mix;
    } t_voice_item;

    typedef struct {
        logic [23:0] mix_out;
        logic        active;
    } t_voice_out;

    // own model of the voice plus the queue of pending samples
    class voice_scoreboard;
        int          sine_tab [1024];
        logic [17:0] rate;
        t_env_phase  phase;
        logic [20:0] count;
        logic [13:0] wave_pos;
        logic [13:0] period;
        logic [15:0] note_gain;
        logic [20:0] atk_len;
        logic [20:0] rel_len;
        t_voice_out  pending [$];
        int          errors;

        function new();
            for (int i = 0; i < 1024; i++) sine_tab[i] = sine_at(i);
            rate      = 18'd48000;
            phase     = PH_IDLE;
            count     = '0;
            wave_pos  = '0;
            period    = 14'd120;
            note_gain = 16'd3277;
            atk_len   = 21'd1;
            rel_len   = 21'd1;
            errors    = 0;
        endfunction

        function int sine_at(int i);
            logic [63:0] a, x2, term, mag;
            longint      acc;
            logic        neg;
            a   = (64'(i) * TWO_PI_Q30) / 64'd1024;
            neg = 1'b0;
            if (a > PI_Q30) begin
                neg = 1'b1;
                a   = a - PI_Q30;
            end
            if (a > HALF_PI_Q30) a = (a >= PI_Q30) ? 64'd0 : PI_Q30 - a;
            x2   = (a * a) >> 30;
            term = a;
            acc  = longint'(a);
            for (int k = 1; k <= 7; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) acc = acc - longint'(term);
                else acc = acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
            mag = (64'(acc) * SINE_AMP + (ONE_Q30 >> 1)) >> 30;
            if (mag > SINE_AMP) mag = SINE_AMP;
            return neg ? -int'(mag) : int'(mag);
        endfunction

        function logic [20:0] env_len(logic [15:0] ms);
            logic [63:0] n;
            n = (64'(ms) * 64'(rate) + 64'd500) / 64'd1000;
            if (n < 1) n = 1;
            return n[20:0];
        endfunction

        function void note_input(t_voice_item it);
            logic [15:0] f, g, at, rl;
            logic [31:0] p;
            longint      env, gs, voice, sum;
            logic [31:0] idx;
            t_voice_out  res;
            case (it.kind)
                KIND_NOTE_ON: begin
                    f  = it.freq < 20 ? 16'd20 : (it.freq > 20000 ? 16'd20000 : it.freq);
                    g  = it.gain > 32768 ? 16'd32768 : it.gain;
                    at = it.atk_ms > 8000 ? 16'd8000 : it.atk_ms;
                    rl = it.rel_ms > 8000 ? 16'd8000 : it.rel_ms;
                    p  = 32'(rate) / 32'(f);
                    if (p < 1) p = 1;
                    if (p > 16383) p = 16383;
                    period    = p[13:0];
                    note_gain = g;
                    atk_len   = env_len(at);
                    rel_len   = env_len(rl);
                    phase     = PH_ATTACK;
                    count     = '0;
                    wave_pos  = '0;
                end
                KIND_NOTE_OFF: begin
                    if (phase == PH_ATTACK || phase == PH_SUSTAIN) phase = PH_RELEASE;
                end
                KIND_TICK: begin
                    case (phase)
                        PH_ATTACK: begin
                            env   = (longint'(count) << 16) / longint'(atk_len);
                            count = count + 1'b1;
                            if (count >= atk_len) begin
                                count = '0;
                                phase = PH_SUSTAIN;
                            end
                        end
                        PH_SUSTAIN: env = 65536;
                        PH_RELEASE: begin
                            env   = 65536 - (longint'(count) << 16) / longint'(rel_len);
                            count = count + 1'b1;
                            if (count >= rel_len) begin
                                count = '0;
                                phase = PH_IDLE;
                            end
                        end
                        default: env = 0;
                    endcase
                    if (wave_pos >= period) wave_pos = wave_pos % period;
                    idx   = (32'(wave_pos) * 32'd1024) / 32'(period);
                    gs    = (longint'(note_gain) * longint'(sine_tab[idx])) >>> 15;
                    voice = (env * gs) >>> 16;
                    sum   = longint'($signed(it.mix)) + voice;
                    if (sum > 8388607) sum = 8388607;
                    if (sum < -8388608) sum = -8388608;
                    wave_pos    = 14'((32'(wave_pos) + 1) % 32'(period));
                    res.mix_out = sum[23:0];
                    res.active  = (phase != PH_IDLE);
                    pending.push_back(res);
                end
                default: ;
            endcase
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check(logic [OUT_W-1:0] beat);
            t_voice_out want;
            if (pending.size() == 0) begin
                report("unexpected beat", beat, 0);
            end else begin
                want = pending.pop_front();
                if (beat[23:0] !== want.mix_out)
                    report("mix_out", 32'(beat[23:0]), 32'(want.mix_out));
                if (beat[24] !== want.active)
                    report("voice_active", 32'(beat[24]), 32'(want.active));
            end
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              s_valid;
    logic              s_ready;
    logic [IN_W-1:0]   s_data;
    logic [1:0]        s_user;
    logic              m_valid;
    logic              m_ready;
    logic [OUT_W-1:0]  m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [RATE_W-1:0] cfg_data;

    voice_scoreboard sb;
    int              cycles;
    int              n_sent;

    sine_voice_with_ar_envelope uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task send_item(t_voice_item it);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= it.kind;
        s_data  <= {it.mix, it.rel_ms, it.atk_ms, it.gain, it.freq};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        sb.note_input(it);
        n_sent++;
    endtask

    // hold off until every sample is back, then let note-on/off work drain
    task wait_drained();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_rate(logic [17:0] r);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        sb.rate = r;
    endtask

    function t_voice_item mk(t_kind k, logic [15:0] f, logic [15:0] g,
                             logic [15:0] a, logic [15:0] r, logic [23:0] m);
        t_voice_item it;
        it.kind   = k;
        it.freq   = f;
        it.gain   = g;
        it.atk_ms = a;
        it.rel_ms = r;
        it.mix    = m;
        return it;
    endfunction

    function t_voice_item rand_item(t_kind k, bit wild);
        t_voice_item it;
        it = mk(k, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                24'($urandom));
        if (!wild) begin
            it.freq   = 16'($urandom_range(20, 3000));
            it.gain   = 16'($urandom_range(0, 32768));
            it.atk_ms = 16'($urandom_range(0, 2));
            it.rel_ms = 16'($urandom_range(0, 2));
            if ($urandom_range(0, 3) == 0) it.mix = 24'($urandom_range(0, 255) - 128);
        end
        return it;
    endfunction

    task run_ticks(int n);
        for (int i = 0; i < n; i++) send_item(rand_item(KIND_TICK, 1'b1));
    endtask

    // receive side with random stalls
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            @(posedge i_clk);
            while (!m_valid) @(posedge i_clk);
            sb.check(m_data);
        end
    end

    initial begin
        logic [17:0] rates [6];
        int          sel;
        rates   = '{18'd8000, 18'd192000, 18'd0, 18'd262143, 18'd44100, 18'd48000};
        sb      = new();
        cycles  = 0;
        n_sent  = 0;
        i_rst_n   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        s_user    = KIND_TICK;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle extremes, unused kind, clamps, saturation, early note-off
        send_item(mk(KIND_TICK, 0, 0, 0, 0, 24'h7fffff));
        send_item(mk(KIND_TICK, 0, 0, 0, 0, 24'h800000));
        send_item(mk(KIND_NOTE_OFF, 0, 0, 0, 0, 0));
        send_item(mk(KIND_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 24'hffffff));
        send_item(mk(KIND_TICK, 0, 0, 0, 0, 0));
        send_item(mk(KIND_NOTE_ON, 16'd0, 16'hffff, 16'd0, 16'd0, 0));
        send_item(mk(KIND_TICK, 0, 0, 0, 0, 24'h7fffff));
        send_item(mk(KIND_TICK, 0, 0, 0, 0, 24'h7ff000));
        send_item(mk(KIND_TICK, 0, 0, 0, 0, 24'h800000));
        send_item(mk(KIND_NOTE_ON, 16'hffff, 16'd0, 16'hffff, 16'hffff, 0));
        send_item(mk(KIND_TICK, 0, 0, 0, 0, 24'h123456));
        send_item(mk(KIND_NOTE_ON, 16'd1000, 16'd32768, 16'd1, 16'd0, 0));
        run_ticks(3);
        // release starts with the attack count: envelope goes negative
        send_item(mk(KIND_NOTE_OFF, 0, 0, 0, 0, 0));
        send_item(mk(KIND_TICK, 0, 0, 0, 0, 24'h800000));
        send_item(mk(KIND_TICK, 0, 0, 0, 0, 24'h000000));
        send_item(mk(KIND_NOTE_ON, 16'd440, 16'd20000, 16'd0, 16'd1, 0));
        run_ticks(2);
        send_item(mk(KIND_NOTE_OFF, 0, 0, 0, 0, 0));
        run_ticks(3);

        sel = 0;
        while (n_sent < N_ITEMS) begin
            if (n_sent >= (sel + 1) * (N_ITEMS / 7)) begin
                write_rate(rates[sel % 6]);
                sel++;
            end
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: send_item(rand_item(KIND_NOTE_ON, 1'b1));
                    1: send_item(rand_item(KIND_NOTE_OFF, 1'b1));
                    2: send_item(rand_item(KIND_UNUSED, 1'b1));
                    default: run_ticks($urandom_range(1, 4));
                endcase
            end else begin
                send_item(rand_item(KIND_NOTE_ON, $urandom_range(0, 4) == 0));
                run_ticks($urandom_range(0, 30));
                send_item(rand_item(KIND_NOTE_OFF, 1'b1));
                run_ticks($urandom_range(0, 30));
            end
            if ($urandom_range(0, 40) == 0) wait_drained();
        end

        wait_drained();
        if (sb.errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
